[rtl/ps2mpd_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mpd_pkg
// Shared types and constants for the PS/2 mouse packet event decoder.
// ----------------------------------------------------------------------------
package ps2mpd_pkg;

  localparam int NUM_BUTTONS = 3;

  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;

  localparam logic [1:0] BTN_NONE = 2'd0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] buttons;
    logic [NUM_BUTTONS-1:0] changed;
    logic                   moved;
    logic signed [8:0]      mx;
    logic signed [8:0]      my;
  } pkt_t;

endpackage

[rtl/ps2mpd_front.sv]
// ----------------------------------------------------------------------------
// ps2mpd_front
// Byte assembler: resynchronises on the header sync bit, collects the X and
// Y bytes and queues each completed packet that changes a button or moves.
// ----------------------------------------------------------------------------
module ps2mpd_front
  import ps2mpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       q_push,
  output pkt_t       q_push_data,
  input  logic       q_ready
);

  typedef enum logic [1:0] {
    POS_HDR = 2'd0,
    POS_X   = 2'd1,
    POS_Y   = 2'd2
  } pos_t;

  pos_t                   pos_r, pos_nxt;
  logic [7:0]             header_r, header_nxt;
  logic [7:0]             x_r, x_nxt;
  logic [NUM_BUTTONS-1:0] held_r, held_nxt;
  logic                   accept;
  pkt_t                   pkt;

  assign in_ready = (pos_r != POS_Y) || q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pkt.buttons = header_r[NUM_BUTTONS-1:0];
    pkt.changed = header_r[NUM_BUTTONS-1:0] ^ held_r;
    pkt.mx      = {header_r[HDR_XSIGN_BIT], x_r};
    pkt.my      = {header_r[HDR_YSIGN_BIT], in_data_byte};
    pkt.moved   = (pkt.mx != 9'sd0) || (pkt.my != 9'sd0);
  end

  assign q_push_data = pkt;

  always_comb begin
    pos_nxt    = pos_r;
    header_nxt = header_r;
    x_nxt      = x_r;
    held_nxt   = held_r;
    q_push     = 1'b0;
    if (accept) begin
      case (pos_r)
        POS_X: begin
          x_nxt   = in_data_byte;
          pos_nxt = POS_Y;
        end
        POS_Y: begin
          q_push   = (pkt.changed != '0) || pkt.moved;
          held_nxt = pkt.buttons;
          pos_nxt  = POS_HDR;
        end
        default: begin
          if (in_data_byte[HDR_SYNC_BIT]) begin
            header_nxt = in_data_byte;
            pos_nxt    = POS_X;
          end else begin
            pos_nxt = POS_HDR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    header_r <= header_nxt;
    x_r      <= x_nxt;
    if (!rst_n) begin
      pos_r  <= POS_HDR;
      held_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

[rtl/ps2mpd_queue.sv]
// ----------------------------------------------------------------------------
// ps2mpd_queue
// Short packet queue between the byte assembler and the event sequencer.
// ----------------------------------------------------------------------------
module ps2mpd_queue
  import ps2mpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pkt_t push_data,
  output logic ready,
  input  logic pop,
  output logic valid,
  output pkt_t pop_data
);

  pkt_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign ready    = (count_r != QUEUE_CW'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue fill count exceeds depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == QUEUE_CW'(QUEUE_DEPTH)) && !do_pop |=> count_r == QUEUE_CW'(QUEUE_DEPTH))
    else $error("full queue lost an entry without a pop");

endmodule

[rtl/ps2mpd_back.sv]
// ----------------------------------------------------------------------------
// ps2mpd_back
// Event sequencer: walks the changed buttons of one packet in button order,
// then the movement, and drives one event per transfer on the result port.
// ----------------------------------------------------------------------------
module ps2mpd_back
  import ps2mpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pkt_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic [1:0]        out_button_index,
  output logic signed [8:0] out_move_x,
  output logic signed [8:0] out_move_y,
  output logic              out_last_event
);

  logic                   cur_valid_r, cur_valid_nxt;
  logic [NUM_BUTTONS-1:0] rem_r, rem_nxt;
  logic [NUM_BUTTONS-1:0] newb_r;
  logic                   mv_r, mv_nxt;
  logic signed [8:0]      mx_r, my_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             kind_r, idx_r;
  logic signed [8:0]      ox_r, oy_r;
  logic                   last_r;

  logic                   found;
  logic [1:0]             sel_idx;
  logic [NUM_BUTTONS-1:0] rem_clr;
  logic                   emit;
  logic [1:0]             ev_kind, ev_idx;
  logic signed [8:0]      ev_x, ev_y;
  logic                   ev_last;

  assign emit  = cur_valid_r && (!out_valid_r || out_ready);
  assign q_pop = q_valid && !cur_valid_r;

  always_comb begin
    found   = 1'b0;
    sel_idx = BTN_NONE;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (rem_r[i] && !found) begin
        found   = 1'b1;
        sel_idx = 2'(i);
      end
    end
    rem_clr = rem_r & ~(NUM_BUTTONS'(1) << sel_idx);
    if (found) begin
      ev_kind = newb_r[sel_idx] ? KIND_DOWN : KIND_UP;
      ev_idx  = sel_idx;
      ev_x    = 9'sd0;
      ev_y    = 9'sd0;
      ev_last = (rem_clr == '0) && !mv_r;
    end else begin
      ev_kind = KIND_MOVE;
      ev_idx  = BTN_NONE;
      ev_x    = mx_r;
      ev_y    = my_r;
      ev_last = 1'b1;
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    rem_nxt       = rem_r;
    mv_nxt        = mv_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (found) begin
        rem_nxt = rem_clr;
      end else begin
        mv_nxt = 1'b0;
      end
      cur_valid_nxt = !ev_last;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      rem_nxt       = q_data.changed;
      mv_nxt        = q_data.moved;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    mv_r  <= mv_nxt;
    if (q_pop) begin
      newb_r <= q_data.buttons;
      mx_r   <= q_data.mx;
      my_r   <= q_data.my;
    end
    if (emit) begin
      kind_r <= ev_kind;
      idx_r  <= ev_idx;
      ox_r   <= ev_x;
      oy_r   <= ev_y;
      last_r <= ev_last;
    end
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_button_index = idx_r;
  assign out_move_x       = ox_r;
  assign out_move_y       = oy_r;
  assign out_last_event   = last_r;

  a_work_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (rem_r != '0) || mv_r)
    else $error("active packet holds no pending event");

  a_move_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == KIND_MOVE) |-> (idx_r == BTN_NONE) && last_r)
    else $error("movement event not last or has a button index");

  a_button_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r != KIND_MOVE) |-> (ox_r == 9'sd0) && (oy_r == 9'sd0))
    else $error("button event carries movement");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && emit && found |=> (rem_r & ~$past(rem_r)) == '0 || $past(q_pop))
    else $error("pending button set grew without a new packet");

endmodule

[rtl/ps2_mouse_packet_event_decoder.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_event_decoder
// Assembles 3-byte PS/2 mouse packets and emits button and movement events.
// ----------------------------------------------------------------------------
// One byte is taken per input transfer, and a byte may follow in every cycle
// while the packet queue has room. A header byte without bit 3 set is dropped
// to resynchronise the stream. Each completed packet yields zero to four
// events: one down or up event per changed button (left, right, middle), then
// one movement event if X or Y is nonzero, with the final event flagged. The
// event sequencer issues one event per cycle while the result port is not
// stalled and takes a new packet only after the last event of the one before;
// a two-entry packet queue lets byte intake run on while events drain.
module ps2_mouse_packet_event_decoder
  import ps2mpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic [1:0]        out_button_index,
  output logic signed [8:0] out_move_x,
  output logic signed [8:0] out_move_y,
  output logic              out_last_event
);

  logic q_push, q_ready, q_pop, q_valid;
  pkt_t q_push_data, q_pop_data;

  ps2mpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_byte(in_data_byte),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .q_ready     (q_ready)
  );

  ps2mpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_data (q_pop_data)
  );

  ps2mpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_button_index(out_button_index),
    .out_move_x      (out_move_x),
    .out_move_y      (out_move_y),
    .out_last_event  (out_last_event)
  );

endmodule

[verif/tb_ps2_mouse_packet_event_decoder.sv]
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_event_decoder
// Byte-stream test of the PS/2 mouse packet event decoder.
// ----------------------------------------------------------------------------
// Mouse bytes are pushed through the input channel. Each transfer goes to a
// scoreboard that rebuilds the packet, works out the button and movement
// events it should raise, and queues them. Each event leaving the block is
// checked field by field against the oldest queued one. A directed burst
// covers dropped headers, silent packets, every button edge, full-range and
// -256 movement and ignored overflow bits. Random packets follow, with stray
// and cut-short packets mixed in, and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_event_decoder;
  import ps2mpd_pkg::*;

  typedef struct {
    logic [1:0]        kind;
    logic [1:0]        button;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              last;
  } mouse_event_t;

  class ps2_event_scoreboard;
    mouse_event_t      due_events[$];
    logic [1:0]        byte_slot;
    logic [7:0]        hdr_byte;
    logic [7:0]        x_lo;
    logic [2:0]        buttons_held;
    int                errors;

    function new();
      byte_slot    = 2'd0;
      hdr_byte     = 8'h00;
      x_lo         = 8'h00;
      buttons_held = 3'b000;
      errors       = 0;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [2:0]        now_held;
      logic [2:0]        changed;
      logic signed [8:0] dx;
      logic signed [8:0] dy;
      mouse_event_t      ev;
      int                first;
      if (byte_slot == 2'd3) byte_slot = 2'd0;
      case (byte_slot)
        2'd1: begin
          x_lo      = b;
          byte_slot = 2'd2;
        end
        2'd2: begin
          dx       = {hdr_byte[HDR_XSIGN_BIT], x_lo};
          dy       = {hdr_byte[HDR_YSIGN_BIT], b};
          now_held = hdr_byte[2:0];
          changed  = now_held ^ buttons_held;
          first    = due_events.size();
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (changed[i]) begin
              ev.kind   = now_held[i] ? KIND_DOWN : KIND_UP;
              ev.button = 2'(i);
              ev.dx     = 9'sd0;
              ev.dy     = 9'sd0;
              ev.last   = 1'b0;
              due_events.push_back(ev);
            end
          end
          if (dx != 9'sd0 || dy != 9'sd0) begin
            ev.kind   = KIND_MOVE;
            ev.button = BTN_NONE;
            ev.dx     = dx;
            ev.dy     = dy;
            ev.last   = 1'b0;
            due_events.push_back(ev);
          end
          if (due_events.size() > first) due_events[due_events.size() - 1].last = 1'b1;
          buttons_held = now_held;
          byte_slot    = 2'd0;
        end
        default: begin
          if (b[HDR_SYNC_BIT]) begin
            hdr_byte  = b;
            byte_slot = 2'd1;
          end
        end
      endcase
    endfunction

    function void match_event(mouse_event_t got);
      mouse_event_t want;
      if (due_events.size() == 0) begin
        flag($sformatf("unexpected event kind=%0d btn=%0d x=%0d y=%0d last=%0b",
                       got.kind, got.button, got.dx, got.dy, got.last));
        return;
      end
      want = due_events.pop_front();
      if (got.kind !== want.kind || got.button !== want.button || got.dx !== want.dx ||
          got.dy !== want.dy || got.last !== want.last) begin
        flag($sformatf({"event exp kind=%0d btn=%0d x=%0d y=%0d last=%0b, ",
                        "got kind=%0d btn=%0d x=%0d y=%0d last=%0b"},
                       want.kind, want.button, want.dx, want.dy, want.last,
                       got.kind, got.button, got.dx, got.dy, got.last));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_data_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_event_kind;
  logic [1:0]        out_button_index;
  logic signed [8:0] out_move_x;
  logic signed [8:0] out_move_y;
  logic              out_last_event;

  ps2_event_scoreboard board = new();
  mouse_event_t        seen;
  bit                  idle_on = 1'b1;
  int                  bytes_sent = 0;

  logic [7:0] directed_bytes [24] = '{
    8'h00, 8'hF7,
    8'h08, 8'h00, 8'h00,
    8'h0F, 8'h7F, 8'h80,
    8'h38, 8'h00, 8'h00,
    8'hC8, 8'hFF, 8'hFF,
    8'h1A, 8'h01, 8'h00,
    8'h08, 8'h00, 8'h00,
    8'h2C, 8'h00, 8'h00,
    8'h04
  };

  ps2_mouse_packet_event_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_button_index (out_button_index),
    .out_move_x       (out_move_x),
    .out_move_y       (out_move_y),
    .out_last_event   (out_last_event)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.kind   = out_event_kind;
      seen.button = out_button_index;
      seen.dx     = out_move_x;
      seen.dy     = out_move_y;
      seen.last   = out_last_event;
      board.match_event(seen);
    end
  end

  initial begin
    int hold;
    out_ready = 1'b0;
    hold      = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    board.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_packet();
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;
    logic [7:0] stray;
    int         shape;
    shape = $urandom_range(0, 15);
    hdr   = 8'($urandom_range(0, 255));
    xb    = 8'($urandom_range(0, 255));
    yb    = 8'($urandom_range(0, 255));
    stray = 8'($urandom_range(0, 255));
    hdr[HDR_SYNC_BIT] = 1'b1;
    if (shape < 3) begin
      hdr[HDR_XSIGN_BIT] = 1'b0;
      hdr[HDR_YSIGN_BIT] = 1'b0;
      xb = 8'h00;
      yb = 8'h00;
    end else if (shape == 3) begin
      hdr[HDR_XSIGN_BIT] = 1'b1;
      hdr[HDR_YSIGN_BIT] = 1'b1;
      xb = 8'h00;
      yb = 8'h00;
    end
    // inject noise: a dropped byte, a stray byte, or a cut-short packet
    if (shape == 13) begin
      stray[HDR_SYNC_BIT] = 1'b0;
      send_byte(stray);
    end else if (shape == 15) begin
      send_byte(stray);
    end
    send_byte(hdr);
    if (shape == 14) return;
    send_byte(xb);
    send_byte(yb);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (board.due_events.size() != 0);
  endtask

  initial begin
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    rst_n        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    // hold off the sender until the event queue is empty
    in_valid <= 1'b0;
    wait_drained();

    while (bytes_sent < 110) begin
      idle_on = ($urandom_range(0, 4) != 0);
      send_random_packet();
    end
    idle_on = 1'b0;
    while (bytes_sent < 168) send_random_packet();
    in_valid <= 1'b0;

    wait_drained();
    repeat (16) @(negedge clk);
    if (board.errors == 0 && board.due_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
